@@ design/vmt_pkg.sv @@
// shared constants, types and register indexes for the vertex matrix transform
// no dependencies; imported by every module of the block
`default_nettype none

package vmt_pkg;

    // fixed field and register geometry
    localparam int COEF_WIDTH     = 16;
    localparam int NUM_ROWS       = 4;
    localparam int NUM_COLS       = 4;
    localparam int REG_WIDTH      = 64;
    localparam int THRESH_WIDTH   = 16;
    localparam int CFG_ADDR_WIDTH = 3;

    // parameter defaults for the top level
    localparam int DEF_COORD_WIDTH = 16;
    localparam int DEF_FRAC_BITS   = 8;

    // configuration register indexes
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ROW0   = 3'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ROW1   = 3'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ROW2   = 3'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ROW3   = 3'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_THRESH = 3'd4;

    // one q8.8 unit for coefficients
    localparam logic [COEF_WIDTH-1:0] COEF_ONE = 16'h0100;

    typedef logic [REG_WIDTH-1:0] mat_row_t;
    typedef logic [NUM_ROWS-1:0][REG_WIDTH-1:0] matrix_t;

    // identity row r: 1.0 on the diagonal
    function automatic mat_row_t identity_row(input int unsigned r);
        mat_row_t row;
        row = '0;
        row[r*COEF_WIDTH +: COEF_WIDTH] = COEF_ONE;
        return row;
    endfunction

endpackage

`default_nettype wire

@@ design/vmt_mul.sv @@
// first pipeline stage: sixteen coefficient by coordinate products
// depends on vmt_pkg
`default_nettype none

module vmt_mul
    import vmt_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [NUM_COLS-1:0][COORD_WIDTH-1:0]  coord,
    input  wire matrix_t                               matrix,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [NUM_ROWS-1:0][NUM_COLS-1:0][COORD_WIDTH+COEF_WIDTH-1:0] prod
);

    localparam int PW = COORD_WIDTH + COEF_WIDTH;

    logic                                     valid_reg;
    logic                                     advance;
    logic [NUM_ROWS-1:0][NUM_COLS-1:0][PW-1:0] prod_reg;
    logic [NUM_ROWS-1:0][NUM_COLS-1:0][PW-1:0] prod_next;

    // stage moves when empty or when downstream takes its item
    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    // signed products, full width
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int k = 0; k < NUM_COLS; k++) begin
                prod_next[r][k] = $signed(coord[k])
                    * $signed(matrix[r][k*COEF_WIDTH +: COEF_WIDTH]);
            end
        end
    end

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    // product registers
    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = valid_reg;
    assign prod      = prod_reg;

endmodule

`default_nettype wire

@@ design/vmt_flush_add.sv @@
// second pipeline stage: flush small products and add them in pairs
// depends on vmt_pkg
`default_nettype none

module vmt_flush_add
    import vmt_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [NUM_ROWS-1:0][NUM_COLS-1:0][COORD_WIDTH+COEF_WIDTH-1:0] prod,
    input  wire logic [THRESH_WIDTH-1:0]     threshold,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [NUM_ROWS-1:0][1:0][COORD_WIDTH+COEF_WIDTH:0] half
);

    localparam int PW = COORD_WIDTH + COEF_WIDTH;
    localparam int HW = PW + 1;

    logic                                  valid_reg;
    logic                                  advance;
    logic [NUM_ROWS-1:0][NUM_COLS-1:0][PW-1:0] kept;
    logic [NUM_ROWS-1:0][1:0][HW-1:0]      half_reg;
    logic [NUM_ROWS-1:0][1:0][HW-1:0]      half_next;

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    // zero every product whose magnitude is below the threshold
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int k = 0; k < NUM_COLS; k++) begin
                logic [PW-1:0] mag;
                mag = prod[r][k][PW-1] ? (~prod[r][k] + PW'(1)) : prod[r][k];
                kept[r][k] = (mag < PW'(threshold)) ? '0 : prod[r][k];
            end
        end
    end

    // pair sums per row
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int h = 0; h < 2; h++) begin
                half_next[r][h] = HW'($signed(kept[r][2*h]))
                    + HW'($signed(kept[r][2*h+1]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            half_reg <= half_next;
        end
    end

    assign out_valid = valid_reg;
    assign half      = half_reg;

endmodule

`default_nettype wire

@@ design/vmt_round_sat.sv @@
// third pipeline stage: row sum, floor shift and saturation into the output register
// depends on vmt_pkg
`default_nettype none

module vmt_round_sat
    import vmt_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [NUM_ROWS-1:0][1:0][COORD_WIDTH+COEF_WIDTH:0] half,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [NUM_ROWS-1:0][COORD_WIDTH-1:0]       coord_out,
    output logic                                       sat_out
);

    localparam int HW = COORD_WIDTH + COEF_WIDTH + 1;
    localparam int SW = HW + 1;

    localparam logic [COORD_WIDTH-1:0] MAX_VAL = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] MIN_VAL = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic                                   valid_reg;
    logic                                   advance;
    logic [NUM_ROWS-1:0][COORD_WIDTH-1:0]   coord_reg;
    logic [NUM_ROWS-1:0][COORD_WIDTH-1:0]   coord_next;
    logic                                   sat_reg;
    logic                                   sat_next;

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    // full row sum, arithmetic shift, clip to coordinate range
    always_comb begin
        sat_next = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++) begin
            logic signed [SW-1:0] sum;
            logic signed [SW-1:0] shifted;
            logic                 in_range;
            sum      = SW'($signed(half[r][0])) + SW'($signed(half[r][1]));
            shifted  = sum >>> FRAC_BITS;
            in_range = (&shifted[SW-1:COORD_WIDTH-1]) || !(|shifted[SW-1:COORD_WIDTH-1]);
            if (in_range) begin
                coord_next[r] = shifted[COORD_WIDTH-1:0];
            end else begin
                coord_next[r] = shifted[SW-1] ? MIN_VAL : MAX_VAL;
                sat_next      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            coord_reg <= coord_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid = valid_reg;
    assign coord_out = coord_reg;
    assign sat_out   = sat_reg;

endmodule

`default_nettype wire

@@ design/vertex_matrix_transform_core.sv @@
// top level of the 4x4 homogeneous vertex transform: config registers and pipeline
// depends on vmt_pkg, vmt_mul, vmt_flush_add, vmt_round_sat
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid / tready        tdata: x_in, y_in, z_in, w_in
//  m_axis    out        tvalid / tready        tdata: x_out .. w_out, tuser: saturated
//  cfg       in         cfg_we (no wait)       cfg_addr, cfg_wdata
//
// one vertex per clock sustained while m_axis_tready stays high; an accepted item passes the
// multiply, flush-add and round-sat stage registers before m_axis_tvalid rises for it
// stages: multiply, flush plus pair add, row sum with shift and saturation
// each stage holds its own valid bit and fills a bubble even while the output waits
// synchronous active-low reset clears valid bits, sets the identity matrix and zero threshold
`default_nettype none

module vertex_matrix_transform_core
    import vmt_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input vertex channel
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: x_in, y_in, z_in, w_in from the lowest bit up
    input  wire logic [((NUM_COLS*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // result channel
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // tdata: x_out, y_out, z_out, w_out from the lowest bit up
    output logic [((NUM_ROWS*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // tuser: saturated
    output logic                              m_axis_tuser,
    // configuration writes
    input  wire logic                         cfg_we,
    input  wire logic [CFG_ADDR_WIDTH-1:0]    cfg_addr,
    input  wire logic [REG_WIDTH-1:0]         cfg_wdata
);

    localparam int OUT_TW = ((NUM_ROWS*COORD_WIDTH+7)/8)*8;
    localparam int PW     = COORD_WIDTH + COEF_WIDTH;
    localparam int HW     = PW + 1;

    matrix_t                                   matrix_reg;
    logic [THRESH_WIDTH-1:0]                   thresh_reg;

    logic [NUM_COLS-1:0][COORD_WIDTH-1:0]      coord_in;
    logic [NUM_ROWS-1:0][NUM_COLS-1:0][PW-1:0] prod;
    logic [NUM_ROWS-1:0][1:0][HW-1:0]          half;
    logic [NUM_ROWS-1:0][COORD_WIDTH-1:0]      coord_out;
    logic                                      mul_valid;
    logic                                      add_ready;
    logic                                      add_valid;
    logic                                      sat_ready;

    // configuration registers, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                matrix_reg[r] <= identity_row(r);
            end
            thresh_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_ROW0:   matrix_reg[0] <= cfg_wdata;
                CFG_ROW1:   matrix_reg[1] <= cfg_wdata;
                CFG_ROW2:   matrix_reg[2] <= cfg_wdata;
                CFG_ROW3:   matrix_reg[3] <= cfg_wdata;
                CFG_THRESH: thresh_reg    <= cfg_wdata[THRESH_WIDTH-1:0];
                default:    ;
            endcase
        end
    end

    assign coord_in = s_axis_tdata[NUM_COLS*COORD_WIDTH-1:0];

    // products
    vmt_mul #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .coord     (coord_in),
        .matrix    (matrix_reg),
        .out_valid (mul_valid),
        .out_ready (add_ready),
        .prod      (prod)
    );

    // flush and pair add
    vmt_flush_add #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_flush_add (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_valid),
        .in_ready  (add_ready),
        .prod      (prod),
        .threshold (thresh_reg),
        .out_valid (add_valid),
        .out_ready (sat_ready),
        .half      (half)
    );

    // row sum, shift and saturation
    vmt_round_sat #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_round_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (add_valid),
        .in_ready  (sat_ready),
        .half      (half),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .coord_out (coord_out),
        .sat_out   (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TW'(coord_out);

endmodule

`default_nettype wire

@@ design/vmt_checker.sv @@
// port-level checks for the vertex transform, bound to the top level
// depends on vmt_pkg and vertex_matrix_transform_core
`default_nettype none

module vmt_checker
    import vmt_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_axis_tvalid,
    input  wire logic                         s_axis_tready,
    input  wire logic                         m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    input  wire logic [((NUM_ROWS*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input  wire logic                         m_axis_tuser
);

    localparam logic [COORD_WIDTH-1:0] MAX_VAL = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] MIN_VAL = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic any_extreme;

    // some component sits at a range limit
    always_comb begin
        any_extreme = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++) begin
            if (m_axis_tdata[r*COORD_WIDTH +: COORD_WIDTH] == MAX_VAL
                || m_axis_tdata[r*COORD_WIDTH +: COORD_WIDTH] == MIN_VAL) begin
                any_extreme = 1'b1;
            end
        end
    end

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a waiting result holds its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a free output lets input flow
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("input blocked while output is free");

    // an accepted item reaches the output when no back pressure holds it
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready
            ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("item did not arrive after three cycles");

    // a clipped result shows a component at a limit
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> any_extreme)
        else $error("saturated flag without a clipped component");

endmodule

bind vertex_matrix_transform_core vmt_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_vmt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/vertex_matrix_transform_core_tb.sv @@
// self-checking testbench for vertex_matrix_transform_core: a directed table, then random phases
// depends on vmt_pkg and vertex_matrix_transform_core; results checked by predictor or table
`default_nettype none

module vertex_matrix_transform_core_tb;
    import vmt_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int COORD_WIDTH = DEF_COORD_WIDTH;
    localparam int FRAC_BITS   = DEF_FRAC_BITS;
    localparam int PIPE_DEPTH  = 3;
    localparam int STALL_PCT   = 14;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 100;
    localparam longint COORD_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    // indexes past the threshold register, which the block must ignore
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_UNMAPPED5 = 3'd5;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_UNMAPPED6 = 3'd6;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_UNMAPPED7 = 3'd7;
    localparam logic [CFG_ADDR_WIDTH-1:0] ROW_REGS [NUM_ROWS] =
        '{CFG_ROW0, CFG_ROW1, CFG_ROW2, CFG_ROW3};
    localparam logic [CFG_ADDR_WIDTH-1:0] UNMAPPED_REGS [3] =
        '{CFG_UNMAPPED5, CFG_UNMAPPED6, CFG_UNMAPPED7};

    typedef logic [NUM_COLS-1:0][COORD_WIDTH-1:0] vertex_t;

    typedef struct packed {
        logic    sat;
        vertex_t comp;
    } vtx_result_t;

    typedef enum logic [1:0] {
        PLAN_WRITE,
        PLAN_SEND,
        PLAN_KNOWN
    } plan_kind_t;

    // one row of the directed table; data is the register value or the vertex
    typedef struct packed {
        plan_kind_t                kind;
        logic [CFG_ADDR_WIDTH-1:0] reg_idx;
        logic [REG_WIDTH-1:0]      data;
        vertex_t                   want;
        logic                      want_sat;
    } plan_step_t;

    localparam int PLAN_LEN = 37;
    localparam plan_step_t PLAN [PLAN_LEN] = '{
        // identity after reset: every vertex comes back unchanged
        '{PLAN_KNOWN, CFG_ROW0, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b0},
        '{PLAN_KNOWN, CFG_ROW0, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF, 1'b0},
        '{PLAN_KNOWN, CFG_ROW0, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 1'b0},
        '{PLAN_KNOWN, CFG_ROW0, 64'hFFFF_0001_7FFF_8000, 64'hFFFF_0001_7FFF_8000, 1'b0},
        '{PLAN_KNOWN, CFG_ROW0, 64'h0100_FF00_0080_FFFF, 64'h0100_FF00_0080_FFFF, 1'b0},
        // largest threshold, written with all upper bits set
        '{PLAN_WRITE, CFG_THRESH, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0},
        '{PLAN_SEND,  CFG_ROW0, 64'hFF00_FF01_0100_00FF, 64'h0, 1'b0},
        '{PLAN_SEND,  CFG_ROW0, 64'h7FFF_8000_00FF_0101, 64'h0, 1'b0},
        '{PLAN_WRITE, CFG_THRESH, 64'h0000_0000_0000_0000, 64'h0, 1'b0},
        // half-scale x: negative odd sums round toward minus infinity
        '{PLAN_WRITE, CFG_ROW0, 64'h0000_0000_0000_0080, 64'h0, 1'b0},
        '{PLAN_SEND,  CFG_ROW0, 64'h0100_0000_0000_FFFF, 64'h0, 1'b0},
        '{PLAN_SEND,  CFG_ROW0, 64'h0100_0000_0000_FFFD, 64'h0, 1'b0},
        // most positive coefficients everywhere
        '{PLAN_WRITE, CFG_ROW0, 64'h7FFF_7FFF_7FFF_7FFF, 64'h0, 1'b0},
        '{PLAN_WRITE, CFG_ROW1, 64'h7FFF_7FFF_7FFF_7FFF, 64'h0, 1'b0},
        '{PLAN_WRITE, CFG_ROW2, 64'h7FFF_7FFF_7FFF_7FFF, 64'h0, 1'b0},
        '{PLAN_WRITE, CFG_ROW3, 64'h7FFF_7FFF_7FFF_7FFF, 64'h0, 1'b0},
        '{PLAN_KNOWN, CFG_ROW0, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF, 1'b1},
        '{PLAN_KNOWN, CFG_ROW0, 64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 1'b1},
        '{PLAN_KNOWN, CFG_ROW0, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b0},
        // most negative coefficients everywhere
        '{PLAN_WRITE, CFG_ROW0, 64'h8000_8000_8000_8000, 64'h0, 1'b0},
        '{PLAN_WRITE, CFG_ROW1, 64'h8000_8000_8000_8000, 64'h0, 1'b0},
        '{PLAN_WRITE, CFG_ROW2, 64'h8000_8000_8000_8000, 64'h0, 1'b0},
        '{PLAN_WRITE, CFG_ROW3, 64'h8000_8000_8000_8000, 64'h0, 1'b0},
        '{PLAN_KNOWN, CFG_ROW0, 64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF, 1'b1},
        '{PLAN_KNOWN, CFG_ROW0, 64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000, 1'b1},
        '{PLAN_SEND,  CFG_ROW0, 64'h0001_0001_0001_0001, 64'h0, 1'b0},
        // writes to unmapped indexes must leave the matrix alone
        '{PLAN_WRITE, CFG_UNMAPPED5, 64'h0000_0000_0000_0000, 64'h0, 1'b0},
        '{PLAN_WRITE, CFG_UNMAPPED7, 64'h0000_0000_0000_0000, 64'h0, 1'b0},
        '{PLAN_SEND,  CFG_ROW0, 64'h0100_0100_0100_0100, 64'h0, 1'b0},
        // translation by two along x, then a partial flush
        '{PLAN_WRITE, CFG_ROW0, 64'h0200_0000_0000_0100, 64'h0, 1'b0},
        '{PLAN_WRITE, CFG_ROW1, 64'h0000_0000_0100_0000, 64'h0, 1'b0},
        '{PLAN_WRITE, CFG_ROW2, 64'h0000_0100_0000_0000, 64'h0, 1'b0},
        '{PLAN_WRITE, CFG_ROW3, 64'h0100_0000_0000_0000, 64'h0, 1'b0},
        '{PLAN_SEND,  CFG_ROW0, 64'h0100_1234_FEDC_0500, 64'h0, 1'b0},
        '{PLAN_WRITE, CFG_THRESH, 64'h0000_0000_0000_4000, 64'h0, 1'b0},
        '{PLAN_SEND,  CFG_ROW0, 64'h0100_0080_FF80_0040, 64'h0, 1'b0},
        '{PLAN_SEND,  CFG_ROW0, 64'h0100_7F00_8100_0200, 64'h0, 1'b0}
    };

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    vertex_t                   s_axis_tdata  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    vertex_t                   m_axis_tdata;
    logic                      m_axis_tuser;
    logic                      cfg_we        = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr      = '0;
    logic [REG_WIDTH-1:0]      cfg_wdata     = '0;

    // mirror of the block's registers
    matrix_t             coef_rows;
    logic [THRESH_WIDTH-1:0] flush_lim;

    vtx_result_t transformed_fifo [$];
    int          mismatches = 0;
    bit          calm       = 1'b0;

    vertex_matrix_transform_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // row sums of flushed products, floor shift, then clip to the coordinate range
    function automatic vtx_result_t transform_vertex(input vertex_t vtx);
        vtx_result_t             res;
        logic signed [COEF_WIDTH-1:0]  coef;
        logic signed [COORD_WIDTH-1:0] coord;
        longint                  acc;
        longint                  prod;
        longint                  lim;
        res = '0;
        lim = flush_lim;
        for (int r = 0; r < NUM_ROWS; r++) begin
            acc = 0;
            for (int k = 0; k < NUM_COLS; k++) begin
                coef  = coef_rows[r][k*COEF_WIDTH +: COEF_WIDTH];
                coord = vtx[k];
                prod  = longint'(coef) * longint'(coord);
                if (((prod < 0) ? -prod : prod) < lim) begin
                    prod = 0;
                end
                acc += prod;
            end
            acc = acc >>> FRAC_BITS;
            if (acc > COORD_MAX) begin
                acc     = COORD_MAX;
                res.sat = 1'b1;
            end else if (acc < COORD_MIN) begin
                acc     = COORD_MIN;
                res.sat = 1'b1;
            end
            res.comp[r] = acc[COORD_WIDTH-1:0];
        end
        return res;
    endfunction

    // mostly modest coefficients, sometimes identity or raw bits
    function automatic mat_row_t random_row(input int unsigned r);
        mat_row_t row;
        row = '0;
        case ($urandom_range(3))
            0: begin
                row[r*COEF_WIDTH +: COEF_WIDTH] = COEF_ONE;
            end
            1: begin
                row = {$urandom, $urandom};
            end
            default: begin
                for (int k = 0; k < NUM_COLS; k++)
                    row[k*COEF_WIDTH +: COEF_WIDTH] =
                        COEF_WIDTH'(int'($urandom_range(1023)) - 512);
            end
        endcase
        return row;
    endfunction

    // raw bits, corner values, or points with unit weight
    function automatic vertex_t random_vertex();
        vertex_t vtx;
        logic [COORD_WIDTH-1:0] corners [5];
        corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        vtx = '0;
        case ($urandom_range(3))
            0: begin
                vtx = {$urandom, $urandom};
            end
            1: begin
                for (int k = 0; k < NUM_COLS; k++)
                    vtx[k] = corners[$urandom_range(4)];
            end
            default: begin
                for (int k = 0; k < NUM_COLS - 1; k++)
                    vtx[k] = COORD_WIDTH'(int'($urandom_range(8191)) - 4096);
                vtx[NUM_COLS-1] = COEF_ONE;
            end
        endcase
        return vtx;
    endfunction

    // stop offering items and wait until the pipeline has emptied
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (transformed_fifo.size() != 0)
            @(posedge aclk);
        repeat (PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] idx,
                             input logic [REG_WIDTH-1:0] val);
        settle();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ROW0, CFG_ROW1, CFG_ROW2, CFG_ROW3: coef_rows[idx] = val;
            CFG_THRESH: flush_lim = val[THRESH_WIDTH-1:0];
            default: ;
        endcase
    endtask

    // offer one vertex, after a random gap unless calm; record its expected result on accept
    task automatic send_vertex(input vertex_t vtx, input bit known, input vtx_result_t typed);
        while (!calm && $urandom_range(99) < STALL_PCT) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom};
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= vtx;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        transformed_fifo.insert(transformed_fifo.size(),
                                known ? typed : transform_vertex(vtx));
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= STALL_PCT);
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        vtx_result_t want;
        string       comp_names [NUM_ROWS];
        comp_names = '{"x_out", "y_out", "z_out", "w_out"};
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (transformed_fifo.size() == 0) begin
                $error("result item with nothing expected: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                want = transformed_fifo.pop_front();
                for (int r = 0; r < NUM_ROWS; r++) begin
                    if (m_axis_tdata[r] !== want.comp[r]) begin
                        $error("%s: expected %0d, got %0d", comp_names[r],
                               $signed(want.comp[r]), $signed(m_axis_tdata[r]));
                        mismatches++;
                    end
                end
                if (m_axis_tuser !== want.sat) begin
                    $error("saturated: expected %0b, got %0b", want.sat, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    // main sequence
    initial begin
        logic [THRESH_WIDTH-1:0] th;
        coef_rows = '0;
        for (int r = 0; r < NUM_ROWS; r++)
            coef_rows[r][r*COEF_WIDTH +: COEF_WIDTH] = COEF_ONE;
        flush_lim = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < PLAN_LEN; i++) begin
            case (PLAN[i].kind)
                PLAN_WRITE: write_reg(PLAN[i].reg_idx, PLAN[i].data);
                PLAN_SEND:  send_vertex(PLAN[i].data, 1'b0, '0);
                default:    send_vertex(PLAN[i].data, 1'b1, {PLAN[i].want_sat, PLAN[i].want});
            endcase
        end

        // random phases, each with a fresh matrix and threshold
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            calm = 1'b0;
            for (int r = 0; r < NUM_ROWS; r++)
                write_reg(ROW_REGS[r], random_row(r));
            case ($urandom_range(3))
                0: th = '0;
                1: th = THRESH_WIDTH'($urandom_range(1, 255));
                2: th = THRESH_WIDTH'($urandom_range(256, 65535));
                default: th = '1;
            endcase
            write_reg(CFG_THRESH, {$urandom, 16'($urandom), th});
            if ($urandom_range(1) == 1)
                write_reg(UNMAPPED_REGS[$urandom_range(2)], {$urandom, $urandom});
            // one phase runs with both sides always ready
            calm = (ph == 3);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_vertex(random_vertex(), 1'b0, '0);
                if ($urandom_range(149) == 0)
                    settle();
            end
        end

        calm = 1'b0;
        settle();
        if (mismatches == 0) begin
            $display("vertex_matrix_transform_core_tb OK");
        end else begin
            $display("vertex_matrix_transform_core_tb NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(CLK_PERIOD * 500_000);
        $display("vertex_matrix_transform_core_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
